// File: hdl/fsjb_pkg.sv
// Shared constants and types for the batch scheduler core.
package fsjb_pkg;

	localparam int MAX_JOBS_DEF = 64;
	localparam int TIME_W       = 16;
	localparam int TICK_W       = 23;
	localparam int IDX_OUT_W    = 6;
	localparam int IN_DATA_W    = 32;
	localparam int OUT_DATA_W   = 80;

	typedef enum logic {
		POLICY_FCFS = 1'b0,
		POLICY_SJF  = 1'b1
	} policy_t;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_SCAN,
		ST_START,
		ST_CALC,
		ST_TAT,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic clear;
		logic en;
	} pick_ctrl_t;

endpackage

// File: hdl/fsjb_cell.sv
// One job cell of the rotating job ring.
module fsjb_cell #(
	parameter int IDX_W = 6
) (
	input  logic                       clk,
	input  logic                       shift_en,
	input  logic                       d_done,
	input  logic [IDX_W-1:0]           d_idx,
	input  logic [fsjb_pkg::TIME_W-1:0] d_at,
	input  logic [fsjb_pkg::TIME_W-1:0] d_bt,
	output logic                       q_done,
	output logic [IDX_W-1:0]           q_idx,
	output logic [fsjb_pkg::TIME_W-1:0] q_at,
	output logic [fsjb_pkg::TIME_W-1:0] q_bt
);
	import fsjb_pkg::*;

	logic                done_q;
	logic [IDX_W-1:0]    idx_q;
	logic [TIME_W-1:0]   at_q;
	logic [TIME_W-1:0]   bt_q;

	always_ff @(posedge clk) begin
		if (shift_en) begin
			done_q <= d_done;
			idx_q  <= d_idx;
			at_q   <= d_at;
			bt_q   <= d_bt;
		end
	end

	assign q_done = done_q;
	assign q_idx  = idx_q;
	assign q_at   = at_q;
	assign q_bt   = bt_q;

endmodule

// File: hdl/fsjb_pick.sv
// Candidate tracker that compares each job leaving the ring head.
module fsjb_pick #(
	parameter int IDX_W = 6
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  fsjb_pkg::pick_ctrl_t        ctrl,
	input  logic [fsjb_pkg::TICK_W-1:0] tick,
	input  logic                        head_done,
	input  logic [IDX_W-1:0]            head_idx,
	input  logic [fsjb_pkg::TIME_W-1:0] head_at,
	input  logic [fsjb_pkg::TIME_W-1:0] head_bt,
	output logic                        b_found,
	output logic [IDX_W-1:0]            b_idx,
	output logic [fsjb_pkg::TIME_W-1:0] b_at,
	output logic [fsjb_pkg::TIME_W-1:0] b_bt,
	output logic [IDX_W-1:0]            m_idx,
	output logic [fsjb_pkg::TIME_W-1:0] m_at,
	output logic [fsjb_pkg::TIME_W-1:0] m_bt,
	output logic [IDX_W-1:0]            f_idx,
	output logic [fsjb_pkg::TIME_W-1:0] f_at,
	output logic [fsjb_pkg::TIME_W-1:0] f_bt
);
	import fsjb_pkg::*;

	logic              b_found_q, m_found_q, f_found_q;
	logic [IDX_W-1:0]  b_idx_q, m_idx_q, f_idx_q;
	logic [TIME_W-1:0] b_at_q, m_at_q, f_at_q;
	logic [TIME_W-1:0] b_bt_q, m_bt_q, f_bt_q;
	logic              elig, arrived, b_upd, m_upd, f_upd;

	// Shortest job: key is burst, then arrival, then index.
	// Earliest arrival: key is arrival, then burst, then index.
	// Load order: key is index alone.
	always_comb begin
		elig    = ctrl.en && !head_done;
		arrived = elig && ({{(TICK_W-TIME_W){1'b0}}, head_at} <= tick);
		b_upd   = arrived && (!b_found_q || head_bt < b_bt_q ||
			(head_bt == b_bt_q && (head_at < b_at_q ||
			(head_at == b_at_q && head_idx < b_idx_q))));
		m_upd   = elig && (!m_found_q || head_at < m_at_q ||
			(head_at == m_at_q && (head_bt < m_bt_q ||
			(head_bt == m_bt_q && head_idx < m_idx_q))));
		f_upd   = elig && (!f_found_q || head_idx < f_idx_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			b_found_q <= 1'b0;
			m_found_q <= 1'b0;
			f_found_q <= 1'b0;
		end else if (ctrl.clear) begin
			b_found_q <= 1'b0;
			m_found_q <= 1'b0;
			f_found_q <= 1'b0;
		end else begin
			if (b_upd) b_found_q <= 1'b1;
			if (m_upd) m_found_q <= 1'b1;
			if (f_upd) f_found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (b_upd) begin
			b_idx_q <= head_idx;
			b_at_q  <= head_at;
			b_bt_q  <= head_bt;
		end
		if (m_upd) begin
			m_idx_q <= head_idx;
			m_at_q  <= head_at;
			m_bt_q  <= head_bt;
		end
		if (f_upd) begin
			f_idx_q <= head_idx;
			f_at_q  <= head_at;
			f_bt_q  <= head_bt;
		end
	end

	assign b_found = b_found_q;
	assign b_idx   = b_idx_q;
	assign b_at    = b_at_q;
	assign b_bt    = b_bt_q;
	assign m_idx   = m_idx_q;
	assign m_at    = m_at_q;
	assign m_bt    = m_bt_q;
	assign f_idx   = f_idx_q;
	assign f_at    = f_at_q;
	assign f_bt    = f_bt_q;

endmodule

// File: hdl/fcfs_sjf_batch_scheduler_core.sv
// Loading takes one input beat per cycle; a full ring holds MAX_JOBS jobs and drops the rest.
// After the beat with tlast, each result needs one full ring rotation to find the next job,
// then the START, CALC and TAT states to select and reckon it, and EMIT, which waits for a free output register.
// A finished result waits in the output register while the next rotation runs.
// Reset clears the control state, the job count and the policy (first come first served);
// the job ring itself is not cleared.
module fcfs_sjf_batch_scheduler_core #(
	parameter int MAX_JOBS = fsjb_pkg::MAX_JOBS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic                            cfg_wdata,    // policy_mode
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [fsjb_pkg::IN_DATA_W-1:0]  s_tdata,      // arrival_time, burst_time
	input  logic                            s_tlast,      // last_process
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// proc_index, idle_before, completion_time, turnaround_time, waiting_time, zero fill
	output logic [fsjb_pkg::OUT_DATA_W-1:0] m_tdata,
	output logic                            m_tlast       // last_result
);
	import fsjb_pkg::*;

	localparam int IDX_W = $clog2(MAX_JOBS);
	localparam int CNT_W = $clog2(MAX_JOBS + 1);

	state_t            state_q, state_d;
	policy_t           policy_q;
	logic [CNT_W-1:0]  count_q, k_q;
	logic [IDX_W-1:0]  pos_q, pend_idx_q, sel_idx_q;
	logic              pend_v_q, idle_q;
	logic [TICK_W-1:0] tick_q, tat_q;
	logic [TIME_W-1:0] sel_at_q, sel_bt_q;

	logic              m_tvalid_q, m_tlast_q;
	logic [OUT_DATA_W-1:0] m_tdata_q;

	logic              cell_done [MAX_JOBS];
	logic [IDX_W-1:0]  cell_idx  [MAX_JOBS];
	logic [TIME_W-1:0] cell_at   [MAX_JOBS];
	logic [TIME_W-1:0] cell_bt   [MAX_JOBS];

	logic              feed_done;
	logic [IDX_W-1:0]  feed_idx;
	logic [TIME_W-1:0] feed_at, feed_bt;
	logic              head_done, shift_en, in_acc, full, pos_valid, out_free;
	logic              is_last, emit_fire, batch_start;
	pick_ctrl_t        pick_ctrl;

	logic              b_found;
	logic [IDX_W-1:0]  b_idx, m_idx, f_idx;
	logic [TIME_W-1:0] b_at, b_bt, m_at, m_bt, f_at, f_bt;

	logic [TICK_W:0]   sum;
	logic [TICK_W-1:0] t_sat, at_ext, bt_ext, wt;

	assign s_tready    = (state_q == ST_LOAD);
	assign in_acc      = s_tvalid && s_tready;
	assign full        = (count_q == CNT_W'(MAX_JOBS));
	assign pos_valid   = (CNT_W'(pos_q) < count_q);
	assign out_free    = !m_tvalid_q || m_tready;
	assign is_last     = (k_q == count_q - CNT_W'(1));
	assign emit_fire   = (state_q == ST_EMIT) && out_free;
	assign batch_start = in_acc && s_tlast;
	assign shift_en    = (in_acc && !full) || (state_q == ST_SCAN);

	// The job that just ran is marked done as it passes the ring head.
	assign head_done = cell_done[MAX_JOBS-1] ||
		(pend_v_q && cell_idx[MAX_JOBS-1] == pend_idx_q);

	always_comb begin
		if (state_q == ST_LOAD) begin
			feed_done = 1'b0;
			feed_idx  = count_q[IDX_W-1:0];
			feed_at   = s_tdata[TIME_W-1:0];
			feed_bt   = s_tdata[2*TIME_W-1:TIME_W];
		end else begin
			feed_done = head_done;
			feed_idx  = cell_idx[MAX_JOBS-1];
			feed_at   = cell_at[MAX_JOBS-1];
			feed_bt   = cell_bt[MAX_JOBS-1];
		end
	end

	for (genvar i = 0; i < MAX_JOBS; i++) begin : g_ring
		if (i == 0) begin : g_first
			fsjb_cell #(.IDX_W(IDX_W)) u_cell (
				.clk(clk), .shift_en(shift_en),
				.d_done(feed_done), .d_idx(feed_idx), .d_at(feed_at), .d_bt(feed_bt),
				.q_done(cell_done[i]), .q_idx(cell_idx[i]), .q_at(cell_at[i]),
				.q_bt(cell_bt[i])
			);
		end else begin : g_next
			fsjb_cell #(.IDX_W(IDX_W)) u_cell (
				.clk(clk), .shift_en(shift_en),
				.d_done(cell_done[i-1]), .d_idx(cell_idx[i-1]), .d_at(cell_at[i-1]),
				.d_bt(cell_bt[i-1]),
				.q_done(cell_done[i]), .q_idx(cell_idx[i]), .q_at(cell_at[i]),
				.q_bt(cell_bt[i])
			);
		end
	end

	assign pick_ctrl.clear = batch_start || (emit_fire && !is_last);
	assign pick_ctrl.en    = (state_q == ST_SCAN) && pos_valid;

	fsjb_pick #(.IDX_W(IDX_W)) u_pick (
		.clk(clk), .arst_n(arst_n), .ctrl(pick_ctrl), .tick(tick_q),
		.head_done(head_done), .head_idx(cell_idx[MAX_JOBS-1]),
		.head_at(cell_at[MAX_JOBS-1]), .head_bt(cell_bt[MAX_JOBS-1]),
		.b_found(b_found), .b_idx(b_idx), .b_at(b_at), .b_bt(b_bt),
		.m_idx(m_idx), .m_at(m_at), .m_bt(m_bt),
		.f_idx(f_idx), .f_at(f_at), .f_bt(f_bt)
	);

	assign at_ext = {{(TICK_W-TIME_W){1'b0}}, sel_at_q};
	assign bt_ext = {{(TICK_W-TIME_W){1'b0}}, sel_bt_q};
	assign sum    = {1'b0, tick_q} + {{(TICK_W+1-TIME_W){1'b0}}, sel_bt_q};
	assign t_sat  = sum[TICK_W] ? {TICK_W{1'b1}} : sum[TICK_W-1:0];
	assign wt     = (tat_q >= bt_ext) ? tat_q - bt_ext : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_LOAD:  if (batch_start) state_d = ST_SCAN;
			ST_SCAN:  if (pos_q == '0) state_d = ST_START;
			ST_START: state_d = ST_CALC;
			ST_CALC:  state_d = ST_TAT;
			ST_TAT:   state_d = ST_EMIT;
			ST_EMIT: begin
				if (out_free) state_d = is_last ? ST_LOAD : ST_SCAN;
			end
			default:  state_d = ST_LOAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q   <= POLICY_FCFS;
			count_q    <= '0;
			k_q        <= '0;
			pos_q      <= '0;
			pend_v_q   <= 1'b0;
			pend_idx_q <= '0;
			tick_q     <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cfg_we) policy_q <= policy_t'(cfg_wdata);
			if (in_acc && !full) count_q <= count_q + CNT_W'(1);
			if (batch_start) begin
				tick_q   <= '0;
				k_q      <= '0;
				pend_v_q <= 1'b0;
				pos_q    <= IDX_W'(MAX_JOBS - 1);
			end
			if (state_q == ST_SCAN) pos_q <= pos_q - IDX_W'(1);
			if (state_q == ST_START) begin
				if (policy_q == POLICY_FCFS) begin
					if ({{(TICK_W-TIME_W){1'b0}}, f_at} > tick_q) begin
						tick_q <= {{(TICK_W-TIME_W){1'b0}}, f_at};
					end
				end else if (!b_found) begin
					tick_q <= {{(TICK_W-TIME_W){1'b0}}, m_at};
				end
			end
			if (state_q == ST_CALC) tick_q <= t_sat;
			if (emit_fire) begin
				m_tvalid_q <= 1'b1;
				pend_v_q   <= 1'b1;
				pend_idx_q <= sel_idx_q;
				k_q        <= k_q + CNT_W'(1);
				pos_q      <= IDX_W'(MAX_JOBS - 1);
				if (is_last) count_q <= '0;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_START) begin
			if (policy_q == POLICY_FCFS) begin
				sel_idx_q <= f_idx;
				sel_at_q  <= f_at;
				sel_bt_q  <= f_bt;
				idle_q    <= ({{(TICK_W-TIME_W){1'b0}}, f_at} > tick_q);
			end else if (b_found) begin
				sel_idx_q <= b_idx;
				sel_at_q  <= b_at;
				sel_bt_q  <= b_bt;
				idle_q    <= 1'b0;
			end else begin
				sel_idx_q <= m_idx;
				sel_at_q  <= m_at;
				sel_bt_q  <= m_bt;
				idle_q    <= 1'b1;
			end
		end
		if (state_q == ST_TAT) begin
			tat_q <= (tick_q >= at_ext) ? tick_q - at_ext : '0;
		end
		if (emit_fire) begin
			m_tdata_q <= {
				{(OUT_DATA_W-IDX_OUT_W-1-3*TICK_W){1'b0}},
				wt, tat_q, tick_q, idle_q, IDX_OUT_W'(sel_idx_q)
			};
			m_tlast_q <= is_last;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;

endmodule

// File: test/sched_checker.sv
// Monitor and scoreboard for the batch scheduler: predicts each schedule and checks every result beat.
module sched_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic                           cfg_wdata,
	input  logic                           s_tvalid,
	input  logic                           s_tready,
	input  logic [fsjb_pkg::IN_DATA_W-1:0]  s_tdata,
	input  logic                           s_tlast,
	input  logic                           m_tvalid,
	input  logic                           m_tready,
	input  logic [fsjb_pkg::OUT_DATA_W-1:0] m_tdata,
	input  logic                           m_tlast,
	output int                             pending,
	output int                             errors
);
	timeunit 1ns;
	timeprecision 1ps;
	import fsjb_pkg::*;

	localparam int unsigned TICK_LIMIT = (1 << TICK_W) - 1;
	localparam int IDLE_BIT = IDX_OUT_W;
	localparam int FIN_LO   = IDX_OUT_W + 1;
	localparam int TAT_LO   = FIN_LO + TICK_W;
	localparam int WAIT_LO  = TAT_LO + TICK_W;

	typedef struct packed {
		logic [IDX_OUT_W-1:0] job;
		logic                 idle;
		logic [TICK_W-1:0]    finish;
		logic [TICK_W-1:0]    turnaround;
		logic [TICK_W-1:0]    waited;
		logic                 tail;
	} sched_result_t;

	policy_t       policy;
	logic [15:0]   arrive_q [MAX_JOBS_DEF];
	logic [15:0]   burst_q [MAX_JOBS_DEF];
	int unsigned   loaded;
	int            fail_count = 0;
	sched_result_t due_results [$];

	function automatic void plan_schedule();
		int unsigned tick, fin, tat, wt, pick, earliest;
		bit idle, any;
		bit ran [MAX_JOBS_DEF];
		sched_result_t r;
		tick = 0;
		for (int i = 0; i < MAX_JOBS_DEF; i++)
			ran[i] = 1'b0;
		for (int k = 0; k < loaded; k++) begin
			if (policy == POLICY_SJF) begin
				any = 1'b0;
				earliest = 0;
				for (int i = 0; i < loaded; i++) begin
					if (!ran[i]) begin
						if (!any || arrive_q[i] < earliest)
							earliest = arrive_q[i];
						any = 1'b1;
					end
				end
				idle = any && earliest > tick;
				if (idle)
					tick = earliest;
				any = 1'b0;
				pick = 0;
				for (int i = 0; i < loaded; i++) begin
					if (!ran[i] && arrive_q[i] <= tick) begin
						if (!any || burst_q[i] < burst_q[pick] ||
								(burst_q[i] == burst_q[pick] && arrive_q[i] < arrive_q[pick])) begin
							pick = i;
							any = 1'b1;
						end
					end
				end
			end else begin
				pick = k;
				idle = arrive_q[k] > tick;
				if (idle)
					tick = arrive_q[k];
			end
			fin = tick + burst_q[pick];
			if (fin > TICK_LIMIT)
				fin = TICK_LIMIT;
			tick = fin;
			ran[pick] = 1'b1;
			tat = (fin >= arrive_q[pick]) ? fin - arrive_q[pick] : 0;
			wt = (tat >= burst_q[pick]) ? tat - burst_q[pick] : 0;
			r.job = IDX_OUT_W'(pick);
			r.idle = idle;
			r.finish = TICK_W'(fin);
			r.turnaround = TICK_W'(tat);
			r.waited = TICK_W'(wt);
			r.tail = (k + 1 == loaded);
			due_results.push_back(r);
		end
	endfunction

	function automatic void compare_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
			fail_count++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		sched_result_t got, want;
		if (!arst_n) begin
			policy = POLICY_FCFS;
			loaded = 0;
			due_results.delete();
		end else begin
			if (cfg_we)
				policy = policy_t'(cfg_wdata);
			if (s_tvalid && s_tready) begin
				if (loaded < MAX_JOBS_DEF) begin
					arrive_q[loaded] = s_tdata[15:0];
					burst_q[loaded] = s_tdata[31:16];
					loaded++;
				end
				if (s_tlast) begin
					plan_schedule();
					loaded = 0;
				end
			end
			if (m_tvalid && m_tready) begin
				got.job = m_tdata[IDX_OUT_W-1:0];
				got.idle = m_tdata[IDLE_BIT];
				got.finish = m_tdata[FIN_LO +: TICK_W];
				got.turnaround = m_tdata[TAT_LO +: TICK_W];
				got.waited = m_tdata[WAIT_LO +: TICK_W];
				got.tail = m_tlast;
				if (due_results.size() == 0) begin
					$display("%0t: unexpected result beat, expected none, got %h last %b",
						$time, m_tdata, m_tlast);
					fail_count++;
				end else begin
					want = due_results.pop_front();
					compare_field("proc_index", want.job, got.job);
					compare_field("idle_before", want.idle, got.idle);
					compare_field("completion_time", want.finish, got.finish);
					compare_field("turnaround_time", want.turnaround, got.turnaround);
					compare_field("waiting_time", want.waited, got.waited);
					compare_field("last_result", want.tail, got.tail);
				end
			end
		end
		pending <= due_results.size();
		errors <= fail_count;
	end

endmodule

// File: test/testbench.sv
// Top of the scheduler testbench: clock, reset, job stimulus, policy writes and the verdict.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import fsjb_pkg::*;

	localparam int SETTLE = 4 * (MAX_JOBS_DEF + 4);
	localparam int LIMIT  = 400000;

	logic                  clk;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic                  cfg_wdata = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic                  s_tlast = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  m_tlast;
	int                    pending;
	int                    errors;
	int                    cycles = 0;
	bit                    calm = 1'b0;

	fcfs_sjf_batch_scheduler_core u_top (.*);
	sched_checker u_check (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk)
		cycles <= cycles + 1;

	initial begin
		wait (cycles >= LIMIT);
		$display("testbench: done, errors");
		$finish;
	end

	always @(negedge clk)
		m_tready <= calm || ($urandom_range(99) >= 23);

	function automatic logic [15:0] draw_time(int mode);
		case (mode)
			0:       return 16'($urandom_range(31));
			1:       return 16'($urandom_range(2047));
			default: return 16'($urandom_range(65535));
		endcase
	endfunction

	task automatic send_job(logic [15:0] arrival, logic [15:0] burst, logic tail);
		@(negedge clk);
		while (!calm && $urandom_range(99) < 23) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {burst, arrival};
		s_tlast <= tail;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	task automatic drain();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic set_policy(logic mode);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= mode;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		int sent, batch, size, amode, bmode;
		logic [15:0] a, b;
		sent = 18;
		batch = 0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset policy is first come first served.
		send_job(16'd0, 16'd0, 1'b0);
		send_job(16'd65535, 16'd65535, 1'b0);
		send_job(16'd3, 16'd4, 1'b0);
		send_job(16'd0, 16'd65535, 1'b0);
		send_job(16'd65535, 16'd0, 1'b1);
		send_job(16'd10, 16'd5, 1'b1);

		// Ties on burst and arrival, idle jumps before and between jobs.
		set_policy(POLICY_SJF);
		send_job(16'd7, 16'd5, 1'b0);
		send_job(16'd2, 16'd9, 1'b0);
		send_job(16'd7, 16'd5, 1'b0);
		send_job(16'd3, 16'd5, 1'b0);
		send_job(16'd40000, 16'd1, 1'b0);
		send_job(16'd40000, 16'd1, 1'b0);
		send_job(16'd0, 16'd0, 1'b0);
		send_job(16'd65535, 16'd65535, 1'b1);
		send_job(16'd65535, 16'd65535, 1'b0);
		send_job(16'd65535, 16'd65534, 1'b0);
		send_job(16'd65535, 16'd65535, 1'b1);

		set_policy(POLICY_FCFS);
		send_job(16'd1, 16'd2, 1'b1);

		while (sent < 210) begin
			if ($urandom_range(1))
				set_policy(1'($urandom_range(1)));
			calm = (batch >= 6 && batch < 9);
			if (batch == 4)
				size = MAX_JOBS_DEF + 6;
			else if ($urandom_range(7) == 0)
				size = $urandom_range(MAX_JOBS_DEF, 20);
			else
				size = $urandom_range(10, 1);
			amode = $urandom_range(2);
			bmode = $urandom_range(2);
			for (int j = 0; j < size; j++) begin
				if ($urandom_range(7) == 0) begin
					a = draw_time(2);
					b = draw_time(2);
				end else begin
					a = draw_time(amode);
					b = draw_time(bmode);
				end
				send_job(a, b, j == size - 1);
			end
			sent += size;
			batch++;
		end
		calm = 1'b0;

		drain();
		if (errors == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule

// File: sim.f
hdl/fsjb_pkg.sv
hdl/fsjb_cell.sv
hdl/fsjb_pick.sv
hdl/fcfs_sjf_batch_scheduler_core.sv
test/sched_checker.sv
test/testbench.sv
